FILE: sv/phsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar span writer package
// Request and result types, register indexes and plane mask tables shared by
// the span writer.
// ----------------------------------------------------------------------------
package phsw_pkg;

	// Span request: one horizontal run of pixels
	typedef struct packed {
		logic [9:0] x_pos;
		logic [7:0] y_pos;
		logic [9:0] span_width;
		logic [7:0] fill_color;
	} phsw_req_t;

	// Write descriptor: one masked burst into video memory
	typedef struct packed {
		logic [15:0] write_address;
		logic [3:0]  plane_mask;
		logic [7:0]  write_data;
		logic [9:0]  byte_count;
		logic        last_write;
	} phsw_wr_t;

	// Configuration port shape
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 16;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH_BYTES = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_OFFSET    = 8'd1;

	// Register reset values
	localparam logic [7:0]  LINE_WIDTH_RESET    = 8'd80;
	localparam logic [15:0] BUFFER_OFFSET_RESET = 16'd0;

	// All four planes enabled
	localparam logic [3:0] ALL_PLANES = 4'hF;

	// Planes from the first pixel of the span to the end of its byte
	function automatic logic [3:0] left_edge_mask(input logic [1:0] col);
		logic [3:0] m;
		unique case (col)
			2'd0: m = 4'd15;
			2'd1: m = 4'd14;
			2'd2: m = 4'd12;
			2'd3: m = 4'd8;
			default: m = 4'd15;
		endcase
		return m;
	endfunction

	// Planes from the start of the byte to the last pixel of the span
	function automatic logic [3:0] right_edge_mask(input logic [1:0] col);
		logic [3:0] m;
		unique case (col)
			2'd0: m = 4'd1;
			2'd1: m = 4'd3;
			2'd2: m = 4'd7;
			2'd3: m = 4'd15;
			default: m = 4'd15;
		endcase
		return m;
	endfunction

endpackage

FILE: sv/planar_hline_span_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar horizontal span writer
// Turns a span request (x, y, width, colour) for a four-plane frame buffer
// into one to three masked write descriptors, none for a dropped span.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive request and raise start; the request transfers at
//   the clock edge where start is high and busy is low.
//   Result channel: each write descriptor is on result for one cycle with
//   result_strobe high. The receiver cannot hold results off.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//   line width (index 0) or the buffer offset (index 1); cfg_ready is always
//   high. Write registers only while the block is idle.
// Timing
//   A span passes the input register and the sequencer stage to the result
//   register. It gives one write (within one byte), two (left and right edge)
//   or three (edges plus a full-plane middle burst), one write per cycle from
//   the output sequencer, which takes the next span as it gives the last write
//   of the current one, so one-byte spans stream at one per cycle.
//   Spans of width zero, or on a line at or beyond MAX_LINES, give no write.
// Reset
//   arst_n clears the valid flags, phase and result strobe and loads the
//   register defaults (line width 80, buffer offset 0). No clearing sweep is needed.
// ----------------------------------------------------------------------------
module planar_hline_span_writer_core #(
	parameter int unsigned MAX_LINES = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  phsw_pkg::phsw_req_t                  request,
	output logic                                 result_strobe,
	output phsw_pkg::phsw_wr_t                   result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [phsw_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [phsw_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import phsw_pkg::*;

	typedef enum logic [1:0] {
		PH_SINGLE,
		PH_LEFT,
		PH_MID,
		PH_RIGHT
	} phase_t;

	// Configuration registers
	logic [7:0]  line_width_q;
	logic [15:0] buffer_offset_q;

	// Input stage
	logic        valid_s1;
	phsw_req_t   req_s1;

	// Sequencer stage
	logic        valid_s2;
	phase_t      phase_s2;
	logic [15:0] addr_s2;
	logic [3:0]  lmask_s2;
	logic [3:0]  rmask_s2;
	logic [8:0]  mid_s2;
	logic [7:0]  color_s2;

	// Result register
	logic        result_strobe_q;
	phsw_wr_t    result_q;

	// Stage 1 decode
	logic        drop_s1;
	logic [10:0] end_sum;
	logic [7:0]  first_byte;
	logic [8:0]  end_byte;
	logic [8:0]  mid_count;
	logic [15:0] line_base;
	logic [15:0] start_addr;
	logic        one_byte;

	// Handshake
	logic        last_phase;
	logic        s2_free;
	logic        move_s1;
	logic        load_s2;
	logic        accept;
	phase_t      next_phase;
	phsw_wr_t    cur_wr;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q    <= LINE_WIDTH_RESET;
			buffer_offset_q <= BUFFER_OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_LINE_WIDTH_BYTES) begin
				line_width_q <= cfg_data[7:0];
			end else if (cfg_index == CFG_BUFFER_OFFSET) begin
				buffer_offset_q <= cfg_data[15:0];
			end
		end
	end

	// Flow control: stage 1 moves on when the sequencer is empty or finishes this cycle
	assign last_phase = (phase_s2 == PH_SINGLE) || (phase_s2 == PH_RIGHT);
	assign s2_free    = !valid_s2 || last_phase;
	assign move_s1    = valid_s1 && s2_free;
	assign load_s2    = move_s1 && !drop_s1;
	assign busy       = valid_s1 && !s2_free;
	assign accept     = start && !busy;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
		end
	end

	// Decode the span: byte range, edge columns and start address
	always_comb begin
		drop_s1    = (req_s1.span_width == 10'd0) || (32'(req_s1.y_pos) >= MAX_LINES);
		end_sum    = 11'({1'b0, req_s1.x_pos} + {1'b0, req_s1.span_width} - 11'd1);
		first_byte = req_s1.x_pos[9:2];
		end_byte   = end_sum[10:2];
		one_byte   = (end_byte == {1'b0, first_byte});
		mid_count  = 9'(end_byte - {1'b0, first_byte} - 9'd1);
		line_base  = {8'd0, req_s1.y_pos} * {8'd0, line_width_q};
		start_addr = 16'(buffer_offset_q + line_base + {8'd0, first_byte});
	end

	// Current write and next phase of the sequencer
	always_comb begin
		cur_wr.write_data = color_s2;
		next_phase        = phase_s2;
		unique case (phase_s2)
			PH_SINGLE: begin
				cur_wr.write_address = addr_s2;
				cur_wr.plane_mask    = lmask_s2 & rmask_s2;
				cur_wr.byte_count    = 10'd1;
				cur_wr.last_write    = 1'b1;
			end
			PH_LEFT: begin
				cur_wr.write_address = addr_s2;
				cur_wr.plane_mask    = lmask_s2;
				cur_wr.byte_count    = 10'd1;
				cur_wr.last_write    = 1'b0;
				next_phase           = (mid_s2 != 9'd0) ? PH_MID : PH_RIGHT;
			end
			PH_MID: begin
				cur_wr.write_address = 16'(addr_s2 + 16'd1);
				cur_wr.plane_mask    = ALL_PLANES;
				cur_wr.byte_count    = {1'b0, mid_s2};
				cur_wr.last_write    = 1'b0;
				next_phase           = PH_RIGHT;
			end
			PH_RIGHT: begin
				cur_wr.write_address = 16'(addr_s2 + 16'd1 + {7'd0, mid_s2});
				cur_wr.plane_mask    = rmask_s2;
				cur_wr.byte_count    = 10'd1;
				cur_wr.last_write    = 1'b1;
			end
			default: begin
				cur_wr.write_address = addr_s2;
				cur_wr.plane_mask    = rmask_s2;
				cur_wr.byte_count    = 10'd1;
				cur_wr.last_write    = 1'b1;
			end
		endcase
	end

	// Sequencer state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2        <= 1'b0;
			phase_s2        <= PH_SINGLE;
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= valid_s2;
			result_q        <= cur_wr;
			if (s2_free) begin
				valid_s2 <= load_s2;
				if (load_s2) begin
					phase_s2 <= one_byte ? PH_SINGLE : PH_LEFT;
					addr_s2  <= start_addr;
					lmask_s2 <= left_edge_mask(req_s1.x_pos[1:0]);
					rmask_s2 <= right_edge_mask(end_sum[1:0]);
					mid_s2   <= mid_count;
					color_s2 <= req_s1.fill_color;
				end
			end else begin
				phase_s2 <= next_phase;
			end
		end
	end

	assign result_strobe = result_strobe_q;
	assign result        = result_q;

	// A span's writes leave in consecutive cycles
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last_write |=> result_strobe)
		else $error("span writes not contiguous");

	// Partial-plane writes always cover a single byte
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result.plane_mask != ALL_PLANES) |-> result.byte_count == 10'd1)
		else $error("edge write with byte count above one");

	// No write is ever empty
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result.byte_count != 10'd0) && (result.plane_mask != 4'd0))
		else $error("empty write descriptor");

	// Busy only while a request waits behind an unfinished span
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s1 && valid_s2 && !last_phase)
		else $error("busy without a pending span");

endmodule

FILE: test/phsw_span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar span writer checker
// Watches the request, configuration and result channels of the span writer.
// Keeps its own copy of the line width and buffer offset, works out the write
// descriptors that each accepted span must give, and compares every result
// strobe against the oldest outstanding descriptor.
// ----------------------------------------------------------------------------
module phsw_span_checker #(
	parameter int unsigned MAX_LINES = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  phsw_pkg::phsw_req_t              request,
	input  logic                             result_strobe,
	input  phsw_pkg::phsw_wr_t               result,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [phsw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [phsw_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               error_count,
	output int                               pending_writes
);
	import phsw_pkg::*;

	// Edge masks packed four bits per column, column 0 in the low nibble
	localparam logic [15:0] LEAD_MASKS  = {4'd8, 4'd12, 4'd14, 4'd15};
	localparam logic [15:0] TRAIL_MASKS = {4'd15, 4'd7, 4'd3, 4'd1};
	localparam int          REPORT_MAX  = 10;

	logic [7:0]  line_width;
	logic [15:0] buf_offset;
	phsw_wr_t    expected_writes_q[$];
	phsw_wr_t    oldest_write;

	// Work out the write descriptors of one span and queue them in order
	function automatic void queue_span_writes(input phsw_req_t r);
		logic [10:0] last_col;
		logic [8:0]  first_byte;
		logic [8:0]  end_byte;
		logic [9:0]  mid_bytes;
		logic [3:0]  lead;
		logic [3:0]  trail;
		logic [15:0] base;
		phsw_wr_t    w;
		if (r.span_width == '0 || int'(r.y_pos) >= int'(MAX_LINES)) begin
			return;
		end
		last_col   = {1'b0, r.x_pos} + {1'b0, r.span_width} - 11'd1;
		first_byte = {1'b0, r.x_pos[9:2]};
		end_byte   = last_col[10:2];
		lead       = LEAD_MASKS[r.x_pos[1:0]*4 +: 4];
		trail      = TRAIL_MASKS[last_col[1:0]*4 +: 4];
		// 16-bit operands so the sum wraps at the top of video memory
		base = buf_offset + {8'd0, r.y_pos} * {8'd0, line_width} + {7'd0, first_byte};
		w.write_data = r.fill_color;
		if (end_byte == first_byte) begin
			w.write_address = base;
			w.plane_mask    = lead & trail;
			w.byte_count    = 10'd1;
			w.last_write    = 1'b1;
			expected_writes_q.push_back(w);
			return;
		end
		// left edge
		w.write_address = base;
		w.plane_mask    = lead;
		w.byte_count    = 10'd1;
		w.last_write    = 1'b0;
		expected_writes_q.push_back(w);
		// full-plane middle burst, dropped when empty
		mid_bytes = {1'b0, end_byte - first_byte - 9'd1};
		if (mid_bytes != '0) begin
			w.write_address = base + 16'd1;
			w.plane_mask    = ALL_PLANES;
			w.byte_count    = mid_bytes;
			w.last_write    = 1'b0;
			expected_writes_q.push_back(w);
		end
		// right edge
		w.write_address = base + 16'd1 + {6'd0, mid_bytes};
		w.plane_mask    = trail;
		w.byte_count    = 10'd1;
		w.last_write    = 1'b1;
		expected_writes_q.push_back(w);
	endfunction

	// Compare results, predict accepted spans, track register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width = LINE_WIDTH_RESET;
			buf_offset = BUFFER_OFFSET_RESET;
			expected_writes_q.delete();
			error_count    = 0;
			pending_writes = 0;
		end else begin
			if (result_strobe) begin
				if (expected_writes_q.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("unexpected write: addr=%h mask=%h data=%h count=%0d last=%b",
							result.write_address, result.plane_mask, result.write_data,
							result.byte_count, result.last_write);
				end else begin
					oldest_write = expected_writes_q.pop_front();
					if (oldest_write !== result) begin
						error_count++;
						if (error_count <= REPORT_MAX)
							$display("write mismatch: exp %h/%h/%h/%0d/%b got %h/%h/%h/%0d/%b",
								oldest_write.write_address, oldest_write.plane_mask,
								oldest_write.write_data, oldest_write.byte_count,
								oldest_write.last_write, result.write_address,
								result.plane_mask, result.write_data, result.byte_count,
								result.last_write);
					end
				end
			end
			if (start && !busy)
				queue_span_writes(request);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_LINE_WIDTH_BYTES)
					line_width = cfg_data[7:0];
				else if (cfg_index == CFG_BUFFER_OFFSET)
					buf_offset = cfg_data;
			end
			pending_writes = expected_writes_q.size();
		end
	end

endmodule

FILE: test/tb_planar_hline_span_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar span writer testbench
// Drives directed edge spans and a long run of random spans through the span
// writer under several line width and buffer offset settings, with random
// gaps on the request side. The checker beside the block predicts and
// compares every write descriptor; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_planar_hline_span_writer_core;
	import phsw_pkg::*;

	localparam int                   SETTLE_CYCLES  = 8;
	localparam int                   STALL_LIMIT    = 2000;
	localparam int                   PHASE_SPANS    = 62;
	localparam int                   PHASE_COUNT    = 4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW  = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 8'd255;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	phsw_req_t              request;
	logic                   result_strobe;
	phsw_wr_t               result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     error_count;
	int                     pending_writes;
	int                     stall_cycles;
	bit                     allow_gaps;

	planar_hline_span_writer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_strobe(result_strobe),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	phsw_span_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.request       (request),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.pending_writes(pending_writes)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Abort when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles = 0;
		end else begin
			if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Present one span and hold it until it transfers
	task automatic send_span(input logic [9:0] x, input logic [7:0] y,
		input logic [9:0] w, input logic [7:0] colour);
		phsw_req_t r;
		r.x_pos      = x;
		r.y_pos      = y;
		r.span_width = w;
		r.fill_color = colour;
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a number of cycles, with junk on the request bus
	task automatic idle_gap(input int cycles);
		@(negedge clk);
		start   <= 1'b0;
		request <= phsw_req_t'({$urandom, $urandom});
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Hold the sender until every write is out and the pipeline has settled
	task automatic drain_pipeline();
		@(negedge clk);
		start <= 1'b0;
		while (pending_writes != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write transfer
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random span, mostly narrow, a few reaching the full width range
	task automatic send_random_span();
		int          pick;
		logic [9:0]  w;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			w = 10'($urandom_range(1, 12));
		else if (pick < 85)
			w = 10'($urandom_range(13, 200));
		else
			w = 10'($urandom_range(201, 1023));
		send_span(10'($urandom), 8'($urandom), w, 8'($urandom));
	endtask

	initial begin
		int sent;
		int phase;
		arst_n     = 1'b0;
		start      = 1'b0;
		request    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		allow_gaps = 1'b1;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed spans at the reset settings
		send_span(10'd0, 8'd0, 10'd1, 8'h00);
		send_span(10'd1, 8'd0, 10'd1, 8'hFF);
		send_span(10'd2, 8'd5, 10'd1, 8'h5A);
		send_span(10'd3, 8'd7, 10'd1, 8'hA5);
		send_span(10'd1, 8'd10, 10'd2, 8'h11);
		send_span(10'd0, 8'd0, 10'd4, 8'h22);
		idle_gap(3);
		send_span(10'd3, 8'd1, 10'd2, 8'h33);
		send_span(10'd0, 8'd2, 10'd8, 8'h44);
		send_span(10'd2, 8'd3, 10'd13, 8'h55);
		send_span(10'd1023, 8'd255, 10'd1, 8'h66);
		send_span(10'd1023, 8'd255, 10'd1023, 8'h77);
		send_span(10'd0, 8'd255, 10'd1023, 8'h88);
		send_span(10'd3, 8'd0, 10'd1023, 8'h99);
		// zero width gives nothing
		send_span(10'd17, 8'd9, 10'd0, 8'hCC);
		send_span(10'd512, 8'd128, 10'd100, 8'hAA);
		drain_pipeline();

		// Widest lines at the top of memory: addresses wrap
		write_reg(CFG_LINE_WIDTH_BYTES, 16'hFFFF);
		write_reg(CFG_BUFFER_OFFSET, 16'hFFFF);
		send_span(10'd0, 8'd0, 10'd1, 8'h01);
		send_span(10'd3, 8'd255, 10'd9, 8'h02);
		send_span(10'd1020, 8'd255, 10'd1023, 8'h03);
		send_span(10'd1023, 8'd255, 10'd1023, 8'h04);
		drain_pipeline();

		// Writes to indexes past the last register must change nothing
		write_reg(CFG_SPARE_LOW, 16'($urandom));
		write_reg(CFG_SPARE_HIGH, 16'h0000);
		send_span(10'd5, 8'd200, 10'd30, 8'h0F);
		send_span(10'd6, 8'd1, 10'd3, 8'hF0);
		drain_pipeline();

		// Random spans under a new setting per phase, no gaps in the last one
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_LINE_WIDTH_BYTES, 16'h0000);
					write_reg(CFG_BUFFER_OFFSET, 16'h0000);
				end
				1: begin
					write_reg(CFG_LINE_WIDTH_BYTES, 16'($urandom));
					write_reg(CFG_BUFFER_OFFSET, 16'($urandom));
				end
				2: begin
					write_reg(CFG_LINE_WIDTH_BYTES, 16'h00FF);
					write_reg(CFG_BUFFER_OFFSET, 16'($urandom_range(16'hFF00, 16'hFFFF)));
				end
				default: begin
					write_reg(CFG_LINE_WIDTH_BYTES, {8'($urandom), 8'd80});
					write_reg(CFG_BUFFER_OFFSET, 16'($urandom));
				end
			endcase
			allow_gaps = (phase != PHASE_COUNT - 1);
			sent = 0;
			while (sent < PHASE_SPANS) begin
				if ($urandom_range(0, 29) == 0) begin
					send_span(10'($urandom), 8'($urandom), 10'd0, 8'($urandom));
				end else begin
					send_random_span();
					sent++;
				end
				if (phase == 1 && sent == PHASE_SPANS / 2)
					drain_pipeline();
				else if (allow_gaps && $urandom_range(0, 3) == 0)
					idle_gap($urandom_range(1, 11));
			end
			drain_pipeline();
		end

		if (error_count == 0 && pending_writes == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
